// ===== sv/lsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// lsfe_pkg: shared types and constants of the six-bit text encoder
// Holds the item structs, the job handed from front to back, the queue
// sizing and the group-to-character mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfe_pkg;

  // Leftover-bit phase codes: no bits, two bits or four bits held.
  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_2 = 2'd1;
  localparam logic [1:0] PH_4 = 2'd2;

  // Alphabet boundaries of the six-bit group.
  localparam logic [5:0] GrpUpper = 6'h1a;
  localparam logic [5:0] GrpDigit = 6'h34;
  localparam logic [5:0] GrpLastDigit = 6'h3d;
  localparam logic [5:0] GrpUnderscore = 6'h3e;
  localparam logic [5:0] GrpDash = 6'h3f;

  // ASCII anchors of the alphabet.
  localparam logic [7:0] AsciiLowerA = 8'h61;
  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiUnderscore = 8'h5f;
  localparam logic [7:0] AsciiDash = 8'h2d;

  // Job queue sizing.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } lsfe_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_last;
  } lsfe_out_t;

  // One accepted byte as a list of one to three groups.
  typedef struct packed {
    logic [1:0]      cnt;   // number of groups, 1 to 3
    logic [2:0][5:0] grp;   // groups in emit order, grp[0] first
    logic            last;  // the final group ends the string
  } lsfe_job_t;

  // Head of the job queue as seen by the back end.
  typedef struct packed {
    logic      valid;
    lsfe_job_t job;
  } lsfe_head_t;

  // Map a six-bit group to its ASCII character.
  function automatic logic [7:0] sixbit_char(input logic [5:0] g);
    logic [7:0] g8;
    g8 = {2'b00, g};
    if (g < GrpUpper) begin
      return AsciiLowerA + g8;
    end else if (g < GrpDigit) begin
      return g8 - {2'b00, GrpUpper} + AsciiUpperA;
    end else if (g <= GrpLastDigit) begin
      return g8 - {2'b00, GrpDigit} + AsciiZero;
    end else if (g == GrpUnderscore) begin
      return AsciiUnderscore;
    end else begin
      return AsciiDash;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/lsfe_front.sv =====
// ----------------------------------------------------------------------------
// lsfe_front: byte intake and group splitting
// Accepts bytes, merges them with the leftover bits and emits one job of
// one to three six-bit groups per byte into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfe_front import lsfe_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lsfe_in_t  in_i,
  input  wire logic      q_full_i,
  output logic           q_push_o,
  output lsfe_job_t      q_job_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [1:0] phase_n;
  logic [3:0] carry_n;
  logic [5:0] tail_grp;
  logic [7:0] b;

  assign b = in_i.in_byte;
  assign in_ready_o = !q_full_i;
  assign q_push_o = in_valid_i && in_ready_o;

  // Split the byte by the current phase, then append the closing group.
  always_comb begin
    q_job_o = '0;
    phase_n = PH_0;
    carry_n = '0;
    unique case (phase_q)
      PH_2: begin
        q_job_o.grp[0] = {b[3:0], carry_q[1:0]};
        q_job_o.cnt = 2'd1;
        carry_n = b[7:4];
        phase_n = PH_4;
      end
      PH_4: begin
        q_job_o.grp[0] = {b[1:0], carry_q};
        q_job_o.grp[1] = b[7:2];
        q_job_o.cnt = 2'd2;
        carry_n = '0;
        phase_n = PH_0;
      end
      default: begin
        q_job_o.grp[0] = b[5:0];
        q_job_o.cnt = 2'd1;
        carry_n = {2'b00, b[7:6]};
        phase_n = PH_2;
      end
    endcase

    // Leftover bits close the string, or a pad group of zero.
    tail_grp = (phase_n != PH_0) ? {2'b00, carry_n} : '0;
    phase_d = phase_n;
    carry_d = carry_n;
    if (in_i.in_last) begin
      if (q_job_o.cnt == 2'd1) begin
        q_job_o.grp[1] = tail_grp;
      end else begin
        q_job_o.grp[2] = tail_grp;
      end
      q_job_o.cnt = q_job_o.cnt + 2'd1;
      q_job_o.last = 1'b1;
      phase_d = PH_0;
      carry_d = '0;
    end
  end

  // Leftover state advances with each accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_0;
      carry_q <= '0;
    end else if (q_push_o) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

  // A final byte always leaves the block with no leftover bits.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o && in_i.in_last |=> phase_q == PH_0 && carry_q == '0)
    else $error("leftover state not cleared after final byte");

endmodule

`default_nettype wire

// ===== sv/lsfe_queue.sv =====
// ----------------------------------------------------------------------------
// lsfe_queue: job queue between front and back
// A small register FIFO that lets the intake and the character output
// stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfe_queue import lsfe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire lsfe_job_t  job_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output lsfe_head_t      head_o
);

  lsfe_job_t               mem_q [QDepth];
  logic [QPtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]        cnt_q;

  assign full_o = (cnt_q == QCntW'(QDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.job = mem_q[rd_ptr_q];

  // Entry storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  // The front never writes a full queue and the back never reads an empty one.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && !head_o.valid))
    else $error("job queue overflow or underflow");

endmodule

`default_nettype wire

// ===== sv/lsfe_back.sv =====
// ----------------------------------------------------------------------------
// lsfe_back: character output sequencer
// Walks the groups of the job at the queue head, maps each to its
// character and presents one item per cycle from an output register while
// a job waits at the queue head and the output is ready.
`default_nettype none

module lsfe_back import lsfe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire lsfe_head_t  head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output lsfe_out_t        out_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  lsfe_out_t  out_q;
  logic       load;
  logic       final_grp;

  assign out_valid_o = out_valid_q;
  assign out_o = out_q;

  // The output register takes a new item when empty or being drained.
  assign load = head_i.valid && (!out_valid_q || out_ready_i);
  assign final_grp = (idx_q == head_i.job.cnt - 2'd1);
  assign pop_o = load && final_grp;

  // Group index within the head job.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= final_grp ? '0 : idx_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_char <= sixbit_char(head_i.job.grp[idx_q]);
      out_q.out_last <= head_i.job.last && final_grp;
    end
  end

  // The index never runs past the groups of the head job.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> idx_q < head_i.job.cnt)
    else $error("group index beyond job length");

  // A job leaves the queue only together with its final group.
  a_pop_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == '0)
    else $error("group index not rewound after pop");

endmodule

`default_nettype wire

// ===== sv/lsb_first_sixbit_text_encoder.sv =====
// A byte is registered in the job queue and then in the output register
// before its first character is valid. One character per cycle goes out while
// ready with a job waiting; one to three per byte, four per three on average.
// A two-entry job queue lets bytes be taken while characters still drain.
// Reset (rst_ni low, asynchronous) clears the leftover bits, the queue and
// the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
// lsb_first_sixbit_text_encoder: LSB-first six-bit text encoder top level
// Packs bytes LSB first into six-bit groups and sends each as a character
// of a URL-style alphabet, with a closing character per string.
// ----------------------------------------------------------------------------
`default_nettype none

module lsb_first_sixbit_text_encoder import lsfe_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire lsfe_in_t  in_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output lsfe_out_t      out_o
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  lsfe_job_t  q_job;
  lsfe_head_t q_head;

  // Intake and group splitting.
  lsfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job)
  );

  // Job queue.
  lsfe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_job),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  // Character output.
  lsfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
